### design/buddy_block_allocator_core_assert.svh
// Assertion macros shared by the buddy allocator RTL.
`ifndef BUDDY_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`define BUDDY_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`ifndef SYNTH
// Check a condition at every clock edge out of reset.
`define BBA_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("bba check failed");
// Check that a condition implies another in the next cycle.
`define BBA_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("bba sequence check failed");
`else
`define BBA_ASSERT(lbl, cond)
`define BBA_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

### design/bba_pkg.sv
// Shared codes and widths of the buddy block allocator.
package bba_pkg;
    localparam int HDR_W     = 4;
    localparam logic [HDR_W-1:0] HDR_RESET = 4'd9;
    localparam int FIELD_W   = 16;
    localparam int IDATA_W   = 48;
    localparam int ODATA_W   = 24;
    localparam int GORD_W    = 4;
    localparam int STATUS_W  = 2;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOFIT = 2'd2;
endpackage

### design/bba_mem.sv
// Single-port block table memory with registered read data.
module bba_mem #(
    parameter int AW = 12,
    parameter int DW = 5
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [DW-1:0] wdata,
    output logic [DW-1:0] rdata
);
    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;
endmodule

### design/buddy_block_allocator_core.sv
// Buddy block allocator: first-fit search, lazy merge and split over a block table.
// An allocate runs the order search, then walks the block headers, with a merge pass over
// the headers when the first search fails, then halves the block found and hands off.
// One item is in work at a time; the walk over the single-port table sets the rate.
// Reset: a clearing pass fills the table before the first request is taken.
module buddy_block_allocator_core #(
    parameter int POOL_LOG2      = 16,
    parameter int MIN_BLOCK_LOG2 = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bba_pkg::HDR_W-1:0]     cfg_wdata,     // header_bytes
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [bba_pkg::IDATA_W-1:0]   s_axis_tdata,  // elem_size, elem_count, block_offset
    input  logic                          s_axis_tuser,  // cmd
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [bba_pkg::ODATA_W-1:0]   m_axis_tdata,  // granted_offset, granted_order, pad
    output logic [bba_pkg::STATUS_W-1:0]  m_axis_tuser   // status
);
    localparam int MAX_ORDER = POOL_LOG2 - MIN_BLOCK_LOG2;
    localparam int NUM_UNITS = 1 << MAX_ORDER;
    localparam int AW = (MAX_ORDER > 0) ? MAX_ORDER : 1;
    localparam int UW = MAX_ORDER + 1;
    localparam int OW = $clog2(MAX_ORDER + 2);
    localparam int DW = OW + 1;
    localparam int PW = 34;
    localparam logic [OW-1:0] MAX_ORD = OW'(MAX_ORDER);

    localparam logic [4:0] S_CLR  = 5'd0;
    localparam logic [4:0] S_IDLE = 5'd1;
    localparam logic [4:0] S_MUL  = 5'd2;
    localparam logic [4:0] S_CHK  = 5'd3;
    localparam logic [4:0] S_NEED = 5'd4;
    localparam logic [4:0] S_FRD  = 5'd5;
    localparam logic [4:0] S_FWT  = 5'd6;
    localparam logic [4:0] S_MRA  = 5'd7;
    localparam logic [4:0] S_MWA  = 5'd8;
    localparam logic [4:0] S_MRB  = 5'd9;
    localparam logic [4:0] S_MWB  = 5'd10;
    localparam logic [4:0] S_MWR  = 5'd11;
    localparam logic [4:0] S_SPL1 = 5'd12;
    localparam logic [4:0] S_SPL2 = 5'd13;
    localparam logic [4:0] S_FIN  = 5'd14;
    localparam logic [4:0] S_XRD  = 5'd15;
    localparam logic [4:0] S_XWT  = 5'd16;
    localparam logic [4:0] S_XWR  = 5'd17;
    localparam logic [4:0] S_DONE = 5'd18;

    logic [4:0] state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [bba_pkg::HDR_W-1:0] hdr_reg;
    logic [bba_pkg::FIELD_W-1:0] esz_reg, esz_next, ecnt_reg, ecnt_next;
    logic [31:0] prod_reg, prod_next;
    logic [PW-1:0] bytes_reg, bytes_next, pw_reg, pw_next;
    logic [OW-1:0] need_reg, need_next, ord_reg, ord_next;
    logic [UW-1:0] u_reg, u_next, nx_reg, nx_next, tgt_reg, tgt_next;
    logic merged_reg, merged_next;
    logic afree_reg, afree_next;
    logic [bba_pkg::STATUS_W-1:0] rst_reg, rst_next;
    logic [bba_pkg::FIELD_W-1:0] roff_reg, roff_next;
    logic [bba_pkg::GORD_W-1:0] rord_reg, rord_next;
    logic m_valid_reg, m_valid_next;
    logic [bba_pkg::ODATA_W-1:0] m_data_reg, m_data_next;
    logic [bba_pkg::STATUS_W-1:0] m_user_reg, m_user_next;

    // Table port.
    logic mem_we;
    logic [AW-1:0] mem_addr;
    logic [DW-1:0] mem_wdata, mem_rdata;

    bba_mem #(.AW(AW), .DW(DW)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // Decode the word just read: free flag, raw order and block length in units.
    logic          rd_free;
    logic [OW-1:0] rd_ord, rd_ordc;
    logic [UW-1:0] rd_units, rd_nu;
    assign rd_free  = mem_rdata[DW-1];
    assign rd_ord   = mem_rdata[OW-1:0];
    assign rd_ordc  = (rd_ord > MAX_ORD) ? MAX_ORD : rd_ord;
    assign rd_units = UW'(1) << rd_ordc;
    assign rd_nu    = u_reg + rd_units;

    // Free request decode at the input.
    logic [15:0] in_off;
    logic [31:0] off_units;
    logic        free_ok;
    assign in_off    = s_axis_tdata[47:32];
    assign off_units = 32'(in_off) >> MIN_BLOCK_LOG2;
    assign free_ok   = ((in_off & 16'((1 << MIN_BLOCK_LOG2) - 1)) == 16'd0) &&
                       (off_units < 32'(NUM_UNITS));

    // Merge candidate: block at u_reg (stored in ord_reg/afree_reg) against its neighbor.
    logic [UW-1:0] a_units, a_mask;
    logic          merge_ok;
    logic [OW-1:0] ord_m1, ord_c;
    assign ord_c    = (ord_reg > MAX_ORD) ? MAX_ORD : ord_reg;
    assign a_units  = UW'(1) << ord_c;
    assign a_mask   = (a_units << 1) - UW'(1);
    assign merge_ok = afree_reg && rd_free && (ord_reg == rd_ord) &&
                      ((u_reg & a_mask) == '0) && (ord_reg < MAX_ORD);
    assign ord_m1   = ord_reg - OW'(1);

    logic [31:0] u_bytes;
    assign u_bytes = 32'(u_reg) << MIN_BLOCK_LOG2;

    assign s_axis_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        esz_next     = esz_reg;
        ecnt_next    = ecnt_reg;
        prod_next    = prod_reg;
        bytes_next   = bytes_reg;
        pw_next      = pw_reg;
        need_next    = need_reg;
        ord_next     = ord_reg;
        u_next       = u_reg;
        nx_next      = nx_reg;
        tgt_next     = tgt_reg;
        merged_next  = merged_reg;
        afree_next   = afree_reg;
        rst_next     = rst_reg;
        roff_next    = roff_reg;
        rord_next    = rord_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        mem_we       = 1'b0;
        mem_addr     = u_reg[AW-1:0];
        mem_wdata    = '0;

        // Drop the result word once taken.
        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLR:
            begin
                // Sweep the table: whole pool free as one block at unit zero.
                mem_we    = 1'b1;
                mem_addr  = clr_reg;
                mem_wdata = {1'b1, (clr_reg == '0) ? MAX_ORD : OW'(0)};
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == AW'(NUM_UNITS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    esz_next  = s_axis_tdata[15:0];
                    ecnt_next = s_axis_tdata[31:16];
                    tgt_next  = off_units[UW-1:0];
                    rst_next  = bba_pkg::ST_OK;
                    roff_next = '0;
                    rord_next = '0;
                    u_next    = '0;
                    if (s_axis_tuser == bba_pkg::CMD_FREE)
                    begin
                        state_next = free_ok ? S_XRD : S_DONE;
                    end
                    else
                    begin
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                prod_next  = 32'(esz_reg) * 32'(ecnt_reg);
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (prod_reg == 32'd0)
                begin
                    rst_next   = bba_pkg::ST_ZERO;
                    state_next = S_DONE;
                end
                else
                begin
                    bytes_next = PW'(prod_reg) + PW'(hdr_reg);
                    pw_next    = PW'(1) << MIN_BLOCK_LOG2;
                    need_next  = '0;
                    state_next = S_NEED;
                end
            end
            S_NEED:
            begin
                // Grow the order one step a cycle until the block covers the request.
                if (need_reg > MAX_ORD)
                begin
                    rst_next   = bba_pkg::ST_NOFIT;
                    state_next = S_DONE;
                end
                else if (pw_reg < bytes_reg)
                begin
                    need_next = need_reg + OW'(1);
                    pw_next   = pw_reg << 1;
                end
                else
                begin
                    u_next      = '0;
                    merged_next = 1'b0;
                    state_next  = S_FRD;
                end
            end
            S_FRD:
            begin
                state_next = S_FWT;
            end
            S_FWT:
            begin
                if (rd_free && (rd_ord >= need_reg))
                begin
                    ord_next   = rd_ord;
                    state_next = (rd_ord > need_reg) ? S_SPL1 : S_FIN;
                end
                else if (rd_nu >= UW'(NUM_UNITS))
                begin
                    if (!merged_reg)
                    begin
                        merged_next = 1'b1;
                        u_next      = '0;
                        state_next  = S_MRA;
                    end
                    else
                    begin
                        rst_next   = bba_pkg::ST_NOFIT;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    u_next     = rd_nu;
                    state_next = S_FRD;
                end
            end
            S_MRA:
            begin
                state_next = S_MWA;
            end
            S_MWA:
            begin
                ord_next   = rd_ord;
                afree_next = rd_free;
                nx_next    = rd_nu;
                if (rd_nu >= UW'(NUM_UNITS))
                begin
                    // Merge pass over: retry the search from the pool start.
                    u_next     = '0;
                    state_next = S_FRD;
                end
                else
                begin
                    state_next = S_MRB;
                end
            end
            S_MRB:
            begin
                mem_addr   = nx_reg[AW-1:0];
                state_next = S_MWB;
            end
            S_MWB:
            begin
                if (merge_ok)
                begin
                    state_next = S_MWR;
                end
                else
                begin
                    u_next     = nx_reg;
                    state_next = S_MRA;
                end
            end
            S_MWR:
            begin
                // Fold the buddy in and look at the grown block again.
                mem_we     = 1'b1;
                mem_wdata  = {1'b1, ord_reg + OW'(1)};
                state_next = S_MRA;
            end
            S_SPL1:
            begin
                // Leave the lower half free, advance into the upper half.
                mem_we     = 1'b1;
                mem_wdata  = {1'b1, ord_m1};
                ord_next   = ord_m1;
                u_next     = u_reg + (UW'(1) << ord_m1);
                state_next = S_SPL2;
            end
            S_SPL2:
            begin
                mem_we     = 1'b1;
                mem_wdata  = {1'b1, ord_reg};
                state_next = (ord_reg > need_reg) ? S_SPL1 : S_FIN;
            end
            S_FIN:
            begin
                mem_we     = 1'b1;
                mem_wdata  = {1'b0, need_reg};
                rst_next   = bba_pkg::ST_OK;
                roff_next  = u_bytes[15:0];
                rord_next  = need_reg[bba_pkg::GORD_W-1:0];
                state_next = S_DONE;
            end
            S_XRD:
            begin
                state_next = S_XWT;
            end
            S_XWT:
            begin
                if (u_reg == tgt_reg)
                begin
                    ord_next   = rd_ord;
                    state_next = S_XWR;
                end
                else if ((rd_nu > tgt_reg) || (rd_nu >= UW'(NUM_UNITS)))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    u_next     = rd_nu;
                    state_next = S_XRD;
                end
            end
            S_XWR:
            begin
                mem_we     = 1'b1;
                mem_wdata  = {1'b1, ord_reg};
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // Hold until the output register is free, then hand the word over.
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_user_next  = rst_reg;
                    m_data_next  = {4'd0, rord_reg, roff_reg};
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLR;
            clr_reg     <= '0;
            hdr_reg     <= bba_pkg::HDR_RESET;
            m_valid_reg <= 1'b0;
            merged_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
            merged_reg  <= merged_next;
            if (cfg_we)
            begin
                hdr_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        esz_reg    <= esz_next;
        ecnt_reg   <= ecnt_next;
        prod_reg   <= prod_next;
        bytes_reg  <= bytes_next;
        pw_reg     <= pw_next;
        need_reg   <= need_next;
        ord_reg    <= ord_next;
        u_reg      <= u_next;
        nx_reg     <= nx_next;
        tgt_reg    <= tgt_next;
        afree_reg  <= afree_next;
        rst_reg    <= rst_next;
        roff_reg   <= roff_next;
        rord_reg   <= rord_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

`include "buddy_block_allocator_core_assert.svh"

    // A zero-size or failed request carries no grant.
    `BBA_ASSERT(a_nogrant, !m_valid_reg || (m_user_reg == bba_pkg::ST_OK) || (m_data_reg == '0))
    // An accepted word keeps the block busy in the next cycle.
    `BBA_ASSERT_NEXT(a_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // No request is taken during the clearing pass.
    `BBA_ASSERT(a_clr, (state_reg != S_CLR) || !s_axis_tready)
endmodule
